// ===== src/kmsd_pkg.sv =====
package kmsd_pkg;

  localparam int ROWS_DEF = 8;
  localparam int COLS_DEF = 8;

  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 8;
  localparam int DRIVE_W  = 8;
  localparam int KEY_W    = 6;
  localparam int HOLD_W   = 16;

  localparam logic [HOLD_W-1:0] DEBOUNCE_RST = 16'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TK_RD,
    S_TK_WR,
    S_PHASE,
    S_RD_ADDR,
    S_RD_EVAL,
    S_FINAL
  } state_e;

  typedef struct packed {
    logic              down;
    logic [HOLD_W-1:0] hold;
  } entry_t;

  typedef struct packed {
    logic   we;
    logic   hit;
    entry_t wr;
  } unit_res_t;

endpackage

// ===== src/key_matrix_scan_debounce_top.sv =====
// Channel  | Handshake                   | Payload
// poll     | in_valid_i / in_stall_o     | time_stamp_i, column_sample_i
// result   | out_valid_o / out_stall_i   | row_drive_o, event_valid_o, key_index_o,
//          |                             | key_press_o, last_o
// config   | cfg_valid_i / cfg_ready_o   | cfg_data_i (debounce ticks)
//
// Select poll: one phase step, then the final result. Read poll: each column in turn,
// an address state and an evaluate state through the holdoff RAM port. A time change
// first reads every key entry and writes back each one still counting down, through the one decrement unit.
// Reset clears per-key valid bits at once; no clearing pass.
// A stalled result can hold the column scan and the final state; polls are taken in idle.
module key_matrix_scan_debounce_top #(
  parameter int ROWS    = kmsd_pkg::ROWS_DEF,
  parameter int COLUMNS = kmsd_pkg::COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [kmsd_pkg::TIME_W-1:0]     time_stamp_i,
  input  logic [kmsd_pkg::SAMPLE_W-1:0]   column_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [kmsd_pkg::DRIVE_W-1:0]    row_drive_o,
  output logic                            event_valid_o,
  output logic [kmsd_pkg::KEY_W-1:0]      key_index_o,
  output logic                            key_press_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kmsd_pkg::HOLD_W-1:0]     cfg_data_i
);

  localparam int NK     = ROWS * COLUMNS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ADDR_W = (NK > 1) ? $clog2(NK) : 1;

  kmsd_pkg::state_e state_q, state_d;

  logic [kmsd_pkg::HOLD_W-1:0]   debounce_q;
  logic [kmsd_pkg::TIME_W-1:0]   prev_time_q;
  logic [kmsd_pkg::SAMPLE_W-1:0] sample_q;
  logic [ROW_W-1:0]              row_q;
  logic                          read_phase_q;
  logic [COL_W-1:0]              col_q;
  logic [ADDR_W-1:0]             idx_q;
  logic [NK-1:0]                 vld_q;
  logic                          held_q;
  logic [kmsd_pkg::KEY_W-1:0]    held_key_q;
  logic                          held_down_q;

  logic                          out_valid_q;
  logic [kmsd_pkg::DRIVE_W-1:0]  out_drive_q;
  logic                          out_ev_q;
  logic [kmsd_pkg::KEY_W-1:0]    out_key_q;
  logic                          out_down_q;
  logic                          out_last_q;

  logic                          accept;
  logic                          out_free;
  logic                          tick_sel;
  logic                          ram_re;
  logic                          advance;
  logic                          out_load;
  logic                          ram_we;
  logic                          pressed;
  logic [31:0]                   key_num;
  logic [31:0]                   sample_sh;
  logic [ADDR_W-1:0]             addr;
  logic [$bits(kmsd_pkg::entry_t)-1:0] rdata;
  kmsd_pkg::entry_t              entry_rd;
  kmsd_pkg::unit_res_t           res;

  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign key_num   = 32'(col_q) * 32'(ROWS) + 32'(row_q);
  assign sample_sh = 32'(sample_q) >> col_q;
  assign pressed   = sample_sh[0];
  assign tick_sel  = (state_q == kmsd_pkg::S_TK_RD) || (state_q == kmsd_pkg::S_TK_WR);
  assign addr      = tick_sel ? idx_q : key_num[ADDR_W-1:0];
  assign entry_rd  = vld_q[addr] ? kmsd_pkg::entry_t'(rdata) : '0;

  kmsd_key_unit u_unit (
    .tick_mode_i (tick_sel),
    .entry_i     (entry_rd),
    .pressed_i   (pressed),
    .debounce_i  (debounce_q),
    .res_o       (res)
  );

  kmsd_ram #(
    .WIDTH ($bits(kmsd_pkg::entry_t)),
    .DEPTH (NK)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (res.wr),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kmsd_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (time_stamp_i != prev_time_q) ? kmsd_pkg::S_TK_RD : kmsd_pkg::S_PHASE;
        end
      end
      kmsd_pkg::S_TK_RD: state_d = kmsd_pkg::S_TK_WR;
      kmsd_pkg::S_TK_WR: begin
        state_d = (idx_q == ADDR_W'(NK - 1)) ? kmsd_pkg::S_PHASE : kmsd_pkg::S_TK_RD;
      end
      kmsd_pkg::S_PHASE: begin
        state_d = read_phase_q ? kmsd_pkg::S_RD_ADDR : kmsd_pkg::S_FINAL;
      end
      kmsd_pkg::S_RD_ADDR: state_d = kmsd_pkg::S_RD_EVAL;
      kmsd_pkg::S_RD_EVAL: begin
        if (advance) begin
          state_d = (col_q == COL_W'(COLUMNS - 1)) ? kmsd_pkg::S_FINAL : kmsd_pkg::S_RD_ADDR;
        end
      end
      kmsd_pkg::S_FINAL: begin
        if (out_free) begin
          state_d = kmsd_pkg::S_IDLE;
        end
      end
      default: state_d = kmsd_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    advance    = 1'b0;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    case (state_q)
      kmsd_pkg::S_IDLE:    in_stall_o = 1'b0;
      kmsd_pkg::S_TK_RD:   ram_re = 1'b1;
      kmsd_pkg::S_TK_WR:   ram_we = res.we;
      kmsd_pkg::S_RD_ADDR: ram_re = 1'b1;
      kmsd_pkg::S_RD_EVAL: begin
        advance  = !(res.hit && held_q && !out_free);
        ram_we   = res.we && advance;
        out_load = res.hit && held_q && out_free;
      end
      kmsd_pkg::S_FINAL:   out_load = out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kmsd_pkg::S_IDLE;
      debounce_q   <= kmsd_pkg::DEBOUNCE_RST;
      prev_time_q  <= '0;
      row_q        <= ROW_W'(ROWS - 1);
      read_phase_q <= 1'b0;
      col_q        <= '0;
      idx_q        <= '0;
      vld_q        <= '0;
      held_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        debounce_q <= cfg_data_i;
      end
      if (accept) begin
        prev_time_q <= time_stamp_i;
        idx_q       <= '0;
        held_q      <= 1'b0;
      end
      if (state_q == kmsd_pkg::S_TK_WR) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
      if (ram_we) begin
        vld_q[addr] <= 1'b1;
      end
      if (state_q == kmsd_pkg::S_PHASE) begin
        read_phase_q <= !read_phase_q;
        col_q        <= '0;
        if (!read_phase_q) begin
          row_q <= (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + ROW_W'(1);
        end
      end
      if (state_q == kmsd_pkg::S_RD_EVAL && advance) begin
        if (res.hit) begin
          held_q <= 1'b1;
        end
        if (col_q != COL_W'(COLUMNS - 1)) begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (state_q == kmsd_pkg::S_FINAL && out_free) begin
        held_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= column_sample_i;
    end
    if (state_q == kmsd_pkg::S_RD_EVAL && advance && res.hit) begin
      held_key_q  <= key_num[kmsd_pkg::KEY_W-1:0];
      held_down_q <= pressed;
    end
    if (out_load) begin
      out_drive_q <= kmsd_pkg::DRIVE_W'(1) << row_q;
      out_ev_q    <= (state_q == kmsd_pkg::S_FINAL) ? held_q : 1'b1;
      out_key_q   <= held_q ? held_key_q : '0;
      out_down_q  <= held_q ? held_down_q : 1'b0;
      out_last_q  <= (state_q == kmsd_pkg::S_FINAL);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_drive_o   = out_drive_q;
  assign event_valid_o = out_ev_q;
  assign key_index_o   = out_key_q;
  assign key_press_o   = out_down_q;
  assign last_o        = out_last_q;

  a_idle_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmsd_pkg::S_IDLE) |-> !held_q)
    else $error("held event left over in idle");

  a_final_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmsd_pkg::S_FINAL && out_free) |=> (state_q == kmsd_pkg::S_IDLE && out_valid_q))
    else $error("final result not issued");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmsd_pkg::S_RD_EVAL && ram_we) |-> (res.wr.hold == debounce_q))
    else $error("holdoff not reloaded with debounce ticks");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_W'(ROWS - 1))
    else $error("row out of range");

endmodule

// ===== src/kmsd_ram.sv =====
module kmsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/kmsd_key_unit.sv =====
module kmsd_key_unit (
  input  logic                          tick_mode_i,
  input  kmsd_pkg::entry_t              entry_i,
  input  logic                          pressed_i,
  input  logic [kmsd_pkg::HOLD_W-1:0]   debounce_i,
  output kmsd_pkg::unit_res_t           res_o
);

  logic idle;

  assign idle = (entry_i.hold == '0);

  always_comb begin
    res_o = '0;
    if (tick_mode_i) begin
      res_o.we      = !idle;
      res_o.hit     = 1'b0;
      res_o.wr.down = entry_i.down;
      res_o.wr.hold = entry_i.hold - kmsd_pkg::HOLD_W'(1);
    end else begin
      res_o.hit     = idle && (pressed_i != entry_i.down);
      res_o.we      = res_o.hit;
      res_o.wr.down = pressed_i;
      res_o.wr.hold = debounce_i;
    end
  end

endmodule

// ===== test/kmsd_scan_checker.sv =====
module kmsd_scan_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [kmsd_pkg::TIME_W-1:0]   time_stamp_i,
  input  logic [kmsd_pkg::SAMPLE_W-1:0] column_sample_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [kmsd_pkg::DRIVE_W-1:0]  row_drive_i,
  input  logic                          event_valid_i,
  input  logic [kmsd_pkg::KEY_W-1:0]    key_index_i,
  input  logic                          key_press_i,
  input  logic                          last_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [kmsd_pkg::HOLD_W-1:0]   cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import kmsd_pkg::*;

  localparam int ROWS       = ROWS_DEF;
  localparam int COLUMNS    = COLS_DEF;
  localparam int NKEYS      = ROWS * COLUMNS;
  localparam int MAX_EVENTS = 8;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               ev;
    logic [KEY_W-1:0]   key;
    logic               down;
    logic               last;
  } scan_res_t;

  scan_res_t         expected_scan_q[$];
  logic [HOLD_W-1:0] hold_reload;
  logic [HOLD_W-1:0] key_hold[NKEYS];
  bit                key_state[NKEYS];
  int                scan_row;
  bit                read_due;
  logic [TIME_W-1:0] last_stamp;

  function automatic scan_res_t make_res(input bit ev, input int key, input bit down,
                                         input bit last);
    scan_res_t r;
    r.drive = '0;
    r.drive[scan_row] = 1'b1;
    r.ev    = ev;
    r.key   = key[KEY_W-1:0];
    r.down  = down;
    r.last  = last;
    return r;
  endfunction

  task automatic predict_poll(input logic [TIME_W-1:0] stamp,
                              input logic [SAMPLE_W-1:0] sample);
    scan_res_t evs[MAX_EVENTS];
    int        n;
    int        key;
    bit        lvl;
    n = 0;
    if (stamp != last_stamp) begin
      for (int i = 0; i < NKEYS; i++) begin
        if (key_hold[i] != '0) key_hold[i] = key_hold[i] - HOLD_W'(1);
      end
    end
    last_stamp = stamp;
    if (!read_due) begin
      scan_row = (scan_row >= ROWS - 1) ? 0 : scan_row + 1;
      read_due = 1'b1;
      expected_scan_q.push_back(make_res(1'b0, 0, 1'b0, 1'b1));
    end else begin
      read_due = 1'b0;
      for (int col = 0; col < COLUMNS; col++) begin
        key = col * ROWS + scan_row;
        if (key < NKEYS && key_hold[key] == '0) begin
          lvl = (col < SAMPLE_W) ? sample[col] : 1'b0;
          if (lvl != key_state[key] && n < MAX_EVENTS) begin
            key_state[key] = lvl;
            key_hold[key]  = hold_reload;
            evs[n] = make_res(1'b1, key, lvl, 1'b0);
            n++;
          end
        end
      end
      if (n == 0) begin
        expected_scan_q.push_back(make_res(1'b0, 0, 1'b0, 1'b1));
      end else begin
        evs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_scan_q.push_back(evs[k]);
      end
    end
  endtask

  task automatic field_check(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    scan_res_t want;
    if (expected_scan_q.size() == 0) begin
      $display("%0t: unexpected result, expected none actual drive %0h ev %0b key %0d",
               $time, row_drive_i, event_valid_i, key_index_i);
      fail_count_o++;
    end else begin
      want = expected_scan_q.pop_front();
      field_check("row_drive", 32'(want.drive), 32'(row_drive_i));
      field_check("event_valid", 32'(want.ev), 32'(event_valid_i));
      field_check("key_index", 32'(want.key), 32'(key_index_i));
      field_check("key_press", 32'(want.down), 32'(key_press_i));
      field_check("last", 32'(want.last), 32'(last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_scan_q.delete();
      hold_reload  = DEBOUNCE_RST;
      scan_row     = ROWS - 1;
      read_due     = 1'b0;
      last_stamp   = '0;
      fail_count_o = 0;
      pending_o    = 0;
      for (int i = 0; i < NKEYS; i++) begin
        key_hold[i]  = '0;
        key_state[i] = 1'b0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) hold_reload = cfg_data_i;
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) predict_poll(time_stamp_i, column_sample_i);
      pending_o = expected_scan_q.size();
    end
  end

endmodule

// ===== test/key_matrix_scan_debounce_top_tb.sv =====
module key_matrix_scan_debounce_top_tb;
  import kmsd_pkg::*;

  localparam int LIMIT_CYCLES = 800000;
  localparam int TAIL_CYCLES  = 2 * COLS_DEF + 16;
  localparam int SQUEEZE_LEN  = 600;
  localparam int PHASE_POLLS  = 44;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [TIME_W-1:0]   time_stamp    = '0;
  logic [SAMPLE_W-1:0] column_sample = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [DRIVE_W-1:0]  row_drive;
  logic                event_valid;
  logic [KEY_W-1:0]    key_index;
  logic                key_press;
  logic                last;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [HOLD_W-1:0]   cfg_data      = '0;
  int                  fail_count;
  int                  pending;
  int                  cycles        = 0;

  bit                  squeeze_req   = 1'b0;
  bit                  squeeze_done  = 1'b0;
  logic [TIME_W-1:0]   now           = '0;
  logic [SAMPLE_W-1:0] held_keys[ROWS_DEF];
  int                  stim_row      = ROWS_DEF - 1;
  bit                  stim_read     = 1'b0;

  key_matrix_scan_debounce_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .time_stamp_i    (time_stamp),
    .column_sample_i (column_sample),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .row_drive_o     (row_drive),
    .event_valid_o   (event_valid),
    .key_index_o     (key_index),
    .key_press_o     (key_press),
    .last_o          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  kmsd_scan_checker scan_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .time_stamp_i    (time_stamp),
    .column_sample_i (column_sample),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .row_drive_i     (row_drive),
    .event_valid_i   (event_valid),
    .key_index_i     (key_index),
    .key_press_i     (key_press),
    .last_i          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stall runs, one long hold-off on request
  initial begin
    int unsigned r;
    int unsigned len;
    bit          lvl;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        lvl = 1'b1;
        len = SQUEEZE_LEN;
      end else if (r < 65) begin
        lvl = 1'b0;
        len = 1;
      end else if (r < 72) begin
        lvl = 1'b0;
        len = $urandom_range(30, 80);
      end else if (r < 94) begin
        lvl = 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        lvl = 1'b1;
        len = $urandom_range(10, 60);
      end
      out_stall <= lvl;
      repeat (len - 1) @(posedge clk);
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] t);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return t + 1;
    if (r < 75) return t;
    if (r < 90) return t + $urandom_range(2, 1000);
    if (r < 97) return $urandom();
    return ~t;
  endfunction

  task automatic poll(input logic [TIME_W-1:0] t, input logic [SAMPLE_W-1:0] s);
    int unsigned g;
    in_valid      <= 1'b1;
    time_stamp    <= t;
    column_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!stim_read) begin
      stim_row  = (stim_row + 1) % ROWS_DEF;
      stim_read = 1'b1;
    end else begin
      stim_read = 1'b0;
    end
    g = sender_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [HOLD_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly slow key changes on the scanned row, some bounce, noise on select polls
  task automatic run_random(input int count);
    logic [SAMPLE_W-1:0] s;
    int unsigned         r;
    for (int n = 0; n < count; n++) begin
      now = next_stamp(now);
      if (!stim_read) begin
        s = SAMPLE_W'($urandom_range(0, 255));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) held_keys[stim_row][$urandom_range(0, SAMPLE_W - 1)] ^= 1'b1;
        else if (r < 38) held_keys[stim_row] = SAMPLE_W'($urandom_range(0, 255));
        s = held_keys[stim_row];
        if ($urandom_range(0, 9) == 0) s[$urandom_range(0, SAMPLE_W - 1)] ^= 1'b1;
      end
      poll(now, s);
    end
  endtask

  initial begin
    for (int i = 0; i < ROWS_DEF; i++) held_keys[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset debounce: all-column press, time wrap, row wrap, releases
    poll(32'h0000_0000, 8'hFF);
    poll(32'h0000_0000, 8'hFF);
    poll(32'hFFFF_FFFF, 8'h00);
    poll(32'hFFFF_FFFF, 8'hA5);
    poll(32'h0000_0000, 8'hFF);
    poll(32'h0000_0000, 8'h00);
    poll(32'h0000_0001, 8'h00);
    poll(32'h0000_0002, 8'h80);
    poll(32'h0000_0003, 8'h00);
    poll(32'h0000_0004, 8'h01);
    poll(32'h0000_0005, 8'h00);
    poll(32'h0000_0006, 8'h5A);
    poll(32'h0000_0007, 8'h00);
    poll(32'h0000_0008, 8'hFF);
    poll(32'h0000_0009, 8'h00);
    poll(32'h0000_000A, 8'hFF);
    poll(32'h0000_000B, 8'h00);
    poll(32'h0000_000C, 8'h00);
    poll(32'h0000_000C, 8'h00);
    poll(32'h0000_000C, 8'h5A);
    poll(32'h0000_000D, 8'h00);
    poll(32'h0000_000D, 8'hFF);
    poll(32'h0000_0014, 8'h00);
    poll(32'h0000_0014, 8'h00);
    now = 32'h0000_0014;
    drain();

    write_debounce(16'd0);
    run_random(PHASE_POLLS);
    drain();

    write_debounce(16'd1);
    run_random(PHASE_POLLS);
    drain();

    write_debounce(16'hFFFF);
    run_random(PHASE_POLLS);
    drain();

    write_debounce(16'd3);
    squeeze_req = 1'b1;
    run_random(PHASE_POLLS);
    drain();

    write_debounce(HOLD_W'($urandom_range(2, 12)));
    run_random(PHASE_POLLS);
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
